// ===== src/plob_pkg.sv =====
// shared types and constants for the price level order book
package plob_pkg;

  localparam int LEVELS = 64;
  localparam int CNT_W  = $clog2(LEVELS + 1);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_QTY  = 2'd1;
  localparam logic [1:0] ST_SIDE_FULL = 2'd2;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_MATCH  = 1'b1;
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    logic        vld;
    logic        op;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] rem;
    logic [31:0] got;
    logic        done;
    logic        app;
    logic [31:0] bb_p;
    logic [31:0] bb_q;
    logic [31:0] ba_p;
    logic [31:0] ba_q;
    logic        ba_f;
  } tok_t;

endpackage

// ===== src/plob_cell.sv =====
// one price level per side, updated as the item word passes by
module plob_cell import plob_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic [31:0] bp_r, bq_r, ap_r, aq_r;
  logic        bu_r, au_r;
  logic [31:0] bp_nxt, bq_nxt, ap_nxt, aq_nxt;
  logic        bu_nxt, au_nxt;
  tok_t        tok_r, tok_nxt;
  logic [32:0] sum;
  logic [31:0] take;

  assign tok_o = tok_r;

  always_comb begin
    bp_nxt  = bp_r;
    bq_nxt  = bq_r;
    bu_nxt  = bu_r;
    ap_nxt  = ap_r;
    aq_nxt  = aq_r;
    au_nxt  = au_r;
    tok_nxt = tok_i;
    sum     = '0;
    take    = '0;
    if (tok_i.vld && tok_i.qty != '0) begin
      if (tok_i.op == OP_ADD) begin
        if (!tok_i.done) begin
          if (tok_i.side == SIDE_BUY) begin
            sum = {1'b0, bq_r} + {1'b0, tok_i.qty};
            if (bu_r && bp_r == tok_i.price) begin
              bq_nxt       = sum[32] ? '1 : sum[31:0];
              tok_nxt.done = 1'b1;
            end else if (!bu_r) begin
              bp_nxt       = tok_i.price;
              bq_nxt       = tok_i.qty;
              bu_nxt       = 1'b1;
              tok_nxt.done = 1'b1;
              tok_nxt.app  = 1'b1;
            end
          end else begin
            sum = {1'b0, aq_r} + {1'b0, tok_i.qty};
            if (au_r && ap_r == tok_i.price) begin
              aq_nxt       = sum[32] ? '1 : sum[31:0];
              tok_nxt.done = 1'b1;
            end else if (!au_r) begin
              ap_nxt       = tok_i.price;
              aq_nxt       = tok_i.qty;
              au_nxt       = 1'b1;
              tok_nxt.done = 1'b1;
              tok_nxt.app  = 1'b1;
            end
          end
        end
      end else begin
        if (tok_i.side == SIDE_BUY) begin
          if (au_r && aq_r != '0 && tok_i.price >= ap_r && tok_i.rem != '0) begin
            take        = (tok_i.rem < aq_r) ? tok_i.rem : aq_r;
            aq_nxt      = aq_r - take;
            tok_nxt.rem = tok_i.rem - take;
            tok_nxt.got = tok_i.got + take;
          end
        end else begin
          if (bu_r && bq_r != '0 && tok_i.price <= bp_r && tok_i.rem != '0) begin
            take        = (tok_i.rem < bq_r) ? tok_i.rem : bq_r;
            bq_nxt      = bq_r - take;
            tok_nxt.rem = tok_i.rem - take;
            tok_nxt.got = tok_i.got + take;
          end
        end
      end
    end
    // fold this level into the running best prices
    if (bu_nxt && bq_nxt != '0 && bp_nxt > tok_i.bb_p) begin
      tok_nxt.bb_p = bp_nxt;
      tok_nxt.bb_q = bq_nxt;
    end
    if (au_nxt && aq_nxt != '0 && (!tok_i.ba_f || ap_nxt < tok_i.ba_p)) begin
      tok_nxt.ba_p = ap_nxt;
      tok_nxt.ba_q = aq_nxt;
      tok_nxt.ba_f = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bu_r  <= 1'b0;
      au_r  <= 1'b0;
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (tok_i.vld) begin
        bu_r <= bu_nxt;
        au_r <= au_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_i.vld) begin
      bp_r <= bp_nxt;
      bq_r <= bq_nxt;
      ap_r <= ap_nxt;
      aq_r <= aq_nxt;
    end
  end

endmodule

// ===== src/price_level_order_book.sv =====
// top level of the price level order book
// usage:
//   in_* carries one order word: operation (0 add, 1 match), side (0 buy, 1 sell),
//   price and quantity. out_* returns one result word per order: status, matched
//   quantity, fully filled flag, best bid/ask price and quantity, level counts
//   and the update sequence, all showing the book after the order.
//   the order word walks a chain of LEVELS cells, one cell per cycle; cell i holds
//   bid level i and ask level i and folds them into the running best prices.
//   one order is in flight at a time: in_stall stays high from accept until the
//   result has been taken.
//   when the receiver holds out_stall the result word stays unchanged on out_*.
//   after reset both sides are empty, the sequence is zero and no result is shown.
module price_level_order_book import plob_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic        in_side,
  input  logic [31:0] in_price,
  input  logic [31:0] in_quantity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_matched_quantity,
  output logic        out_fully_filled,
  output logic [31:0] out_best_bid_price,
  output logic [31:0] out_best_bid_quantity,
  output logic [31:0] out_best_ask_price,
  output logic [31:0] out_best_ask_quantity,
  output logic [6:0]  out_bids_in_use,
  output logic [6:0]  out_asks_in_use,
  output logic [31:0] out_update_sequence
);

  tok_t             tok [0:LEVELS];
  tok_t             tok_r, tok_nxt;
  tok_t             fin;
  logic             busy_r, busy_nxt;
  logic             ov_r, ov_nxt;
  logic [CNT_W-1:0] bcnt_r, bcnt_nxt, acnt_r, acnt_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [1:0]       st_r, st_nxt;
  logic [31:0]      mq_r, mq_nxt;
  logic             ff_r, ff_nxt;
  logic [31:0]      bbp_r, bbq_r, bap_r, baq_r;
  logic             in_acc;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = busy_r;
  assign tok[0]   = tok_r;
  assign fin      = tok[LEVELS];

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    plob_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok[i]),
      .tok_o (tok[i+1])
    );
  end

  always_comb begin
    tok_nxt       = '0;
    tok_nxt.vld   = in_acc;
    tok_nxt.op    = in_operation;
    tok_nxt.side  = in_side;
    tok_nxt.price = in_price;
    tok_nxt.qty   = in_quantity;
    tok_nxt.rem   = in_quantity;
    busy_nxt      = busy_r;
    ov_nxt        = ov_r;
    bcnt_nxt      = bcnt_r;
    acnt_nxt      = acnt_r;
    seq_nxt       = seq_r;
    st_nxt        = st_r;
    mq_nxt        = mq_r;
    ff_nxt        = ff_r;
    if (in_acc) busy_nxt = 1'b1;
    if (ov_r && !out_stall) begin
      ov_nxt   = 1'b0;
      busy_nxt = 1'b0;
    end
    if (fin.vld) begin
      ov_nxt = 1'b1;
      st_nxt = ST_OK;
      mq_nxt = '0;
      ff_nxt = 1'b0;
      if (fin.qty == '0) begin
        st_nxt = ST_ZERO_QTY;
      end else if (fin.op == OP_ADD) begin
        if (!fin.done) begin
          st_nxt = ST_SIDE_FULL;
        end else begin
          seq_nxt = seq_r + 32'd1;
          if (fin.app) begin
            if (fin.side == SIDE_BUY) bcnt_nxt = bcnt_r + CNT_W'(1);
            else acnt_nxt = acnt_r + CNT_W'(1);
          end
        end
      end else begin
        mq_nxt = fin.got;
        if (fin.got != '0) begin
          seq_nxt = seq_r + 32'd1;
          ff_nxt  = (fin.got == fin.qty);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= '0;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      bcnt_r <= '0;
      acnt_r <= '0;
      seq_r  <= '0;
    end else begin
      tok_r  <= tok_nxt;
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      bcnt_r <= bcnt_nxt;
      acnt_r <= acnt_nxt;
      seq_r  <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    mq_r <= mq_nxt;
    ff_r <= ff_nxt;
    if (fin.vld) begin
      bbp_r <= fin.bb_p;
      bbq_r <= fin.bb_q;
      bap_r <= fin.ba_p;
      baq_r <= fin.ba_q;
    end
  end

  assign out_valid             = ov_r;
  assign out_status            = st_r;
  assign out_matched_quantity  = mq_r;
  assign out_fully_filled      = ff_r;
  assign out_best_bid_price    = bbp_r;
  assign out_best_bid_quantity = bbq_r;
  assign out_best_ask_price    = bap_r;
  assign out_best_ask_quantity = baq_r;
  assign out_bids_in_use       = 7'(bcnt_r);
  assign out_asks_in_use       = 7'(acnt_r);
  assign out_update_sequence   = seq_r;

endmodule

// ===== src/plob_checker.sv =====
// port level checks for the price level order book
module plob_checker import plob_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_matched_quantity,
  input logic        out_fully_filled
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an order is in flight");

  a_no_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("result shown too early");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_fill_has_qty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fully_filled |-> out_matched_quantity != '0 && out_status == ST_OK)
    else $error("fill flag without matched quantity");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_matched_quantity))
    else $error("stalled result changed");

endmodule

bind price_level_order_book plob_checker u_plob_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_status           (out_status),
  .out_matched_quantity (out_matched_quantity),
  .out_fully_filled     (out_fully_filled)
);
